/* src/dmx_pkg.sv */
`timescale 1ns / 1ps
package dmx_pkg;

  // Default sizing
  localparam int DEF_MAX_SERVERS = 8;
  localparam int DEF_STAMP_BITS  = 32;

  // Fixed field widths
  localparam int CMD_W   = 3;
  localparam int PEER_W  = 3;
  localparam int MSG_W   = 32;
  localparam int NUM_W   = 4;
  localparam int ENT_W   = 3;
  localparam int APB_W   = 32;
  localparam int PADDR_W = 3;

  // Register addresses
  localparam logic [PADDR_W-1:0] ADDR_MY_INDEX    = 3'd0;
  localparam logic [PADDR_W-1:0] ADDR_NUM_SERVERS = 3'd4;

  typedef enum logic [CMD_W-1:0] {
    CMD_CREQ  = 3'd0,
    CMD_CREL  = 3'd1,
    CMD_DONE  = 3'd2,
    CMD_PREQ  = 3'd3,
    CMD_PREP  = 3'd4,
    CMD_PEXIT = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    MSG_GRANT = 2'd0,
    MSG_REQ   = 2'd1,
    MSG_REPLY = 2'd2,
    MSG_EXIT  = 2'd3
  } msg_kind_t;

  // Peer status as kept in the table
  typedef enum logic [1:0] {
    ST_NORMAL  = 2'd0,
    ST_WAITING = 2'd1,
    ST_GONE    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_PEER,
    S_TAIL,
    S_FLUSH
  } state_t;

  // Message push / end-of-request flush toward the output stage
  typedef struct packed {
    logic                  push;
    logic                  flush;
    msg_kind_t             kind;
    logic [PEER_W-1:0]     dest;
    logic [MSG_W-1:0]      value;
  } emit_req_t;

endpackage

/* src/distributed_mutex_node.sv */
`timescale 1ns / 1ps
// Ricart-Agrawala mutual exclusion node with Lamport timestamps.
// Input channel: an event (client request/release/done, peer request,
// reply or exit) is taken when start is high and busy is low. in_peer
// and in_stamp are only used by peer events.
// Output channel: each outgoing message shows for one cycle with
// out_valid high; out_last marks the final message of an event. The
// receiver cannot stall, so no backpressure exists.
// Config: APB-style port, my_index at 0x0, num_servers at 0x4 (writing
// num_servers also reloads the live-server count).
// Timing: client events walk the peer table (one memory entry per cycle,
// read of the next entry overlapped with update of the current one). A
// client request passes through sweep (while more than one server is
// live), tail and flush; release and done pass through sweep and flush.
// Peer events make a single read-modify-write followed by a flush step,
// which is skipped when the peer is already gone. The last message shows
// in the cycle in which busy drops.
// Events dropped at acceptance leave busy low.
// Reset: all peers normal, no replies awaited, stamps zero, one server.
module distributed_mutex_node #(
  parameter int MAX_SERVERS = dmx_pkg::DEF_MAX_SERVERS,
  parameter int STAMP_BITS  = dmx_pkg::DEF_STAMP_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [dmx_pkg::CMD_W-1:0]    in_cmd,
  input  logic [dmx_pkg::PEER_W-1:0]   in_peer,
  input  logic [dmx_pkg::MSG_W-1:0]    in_stamp,
  output logic                         out_valid,
  output logic [1:0]                   out_msg_kind,
  output logic [dmx_pkg::PEER_W-1:0]   out_dest_peer,
  output logic [dmx_pkg::MSG_W-1:0]    out_msg_value,
  output logic                         out_last,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dmx_pkg::PADDR_W-1:0]  paddr,
  input  logic [dmx_pkg::APB_W-1:0]    pwdata,
  output logic [dmx_pkg::APB_W-1:0]    prdata,
  output logic                         pready
);
  import dmx_pkg::*;

  localparam int NW = $clog2(MAX_SERVERS + 1);
  localparam int IW = $clog2(MAX_SERVERS);

  logic [PEER_W-1:0] my_index;
  logic [NW-1:0]     n_eff;
  logic              live_ld;
  logic [NW-1:0]     live_val;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic [ENT_W-1:0]  wr_data;
  logic [IW-1:0]     rd_addr;
  logic [ENT_W-1:0]  rd_data;
  emit_req_t         req;

  // Register file
  dmx_cfg #(
    .MAX_SERVERS(MAX_SERVERS)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .my_index(my_index),
    .n_eff   (n_eff),
    .live_ld (live_ld),
    .live_val(live_val)
  );

  // Peer table: {awaiting_reply, status}
  dmx_ram #(
    .WIDTH(ENT_W),
    .DEPTH(MAX_SERVERS)
  ) u_table (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // Sequencer and scalar protocol state
  dmx_ctrl #(
    .MAX_SERVERS(MAX_SERVERS),
    .STAMP_BITS (STAMP_BITS)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_cmd  (in_cmd),
    .in_peer (in_peer),
    .in_stamp(in_stamp),
    .my_index(my_index),
    .n_eff   (n_eff),
    .live_ld (live_ld),
    .live_val(live_val),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .req     (req)
  );

  // Output stage with last-message tagging
  dmx_emit u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .req          (req),
    .out_valid    (out_valid),
    .out_msg_kind (out_msg_kind),
    .out_dest_peer(out_dest_peer),
    .out_msg_value(out_msg_value),
    .out_last     (out_last)
  );

endmodule

/* src/dmx_ram.sv */
`timescale 1ns / 1ps
module dmx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/dmx_cfg.sv */
`timescale 1ns / 1ps
module dmx_cfg #(
  parameter int MAX_SERVERS = dmx_pkg::DEF_MAX_SERVERS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [dmx_pkg::PADDR_W-1:0]        paddr,
  input  logic [dmx_pkg::APB_W-1:0]          pwdata,
  output logic [dmx_pkg::APB_W-1:0]          prdata,
  output logic                               pready,
  output logic [dmx_pkg::PEER_W-1:0]         my_index,
  output logic [$clog2(MAX_SERVERS+1)-1:0]   n_eff,
  output logic                               live_ld,
  output logic [$clog2(MAX_SERVERS+1)-1:0]   live_val
);
  import dmx_pkg::*;

  localparam int NW = $clog2(MAX_SERVERS + 1);
  localparam int WW = (NW > NUM_W) ? NW : NUM_W;

  logic [PEER_W-1:0] my_index_r;
  logic [NUM_W-1:0]  num_r;
  logic              wr_hit;

  // Saturate server count into 1..MAX_SERVERS
  function automatic logic [NW-1:0] clamp_n(input logic [NUM_W-1:0] v);
    logic [WW-1:0] x;
    x = WW'(v);
    if (x == '0) begin
      clamp_n = NW'(1);
    end else if (x > WW'(MAX_SERVERS)) begin
      clamp_n = NW'(MAX_SERVERS);
    end else begin
      clamp_n = NW'(x);
    end
  endfunction

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      my_index_r <= '0;
      num_r      <= NUM_W'(1);
    end else if (wr_hit) begin
      if (paddr[2]) begin
        num_r <= pwdata[NUM_W-1:0];
      end else begin
        my_index_r <= pwdata[PEER_W-1:0];
      end
    end
  end

  // Count reload goes straight to the live-server counter
  assign live_ld  = wr_hit && paddr[2];
  assign live_val = clamp_n(pwdata[NUM_W-1:0]);

  assign my_index = my_index_r;
  assign n_eff    = clamp_n(num_r);
  assign prdata   = paddr[2] ? APB_W'(num_r) : APB_W'(my_index_r);

endmodule

/* src/dmx_emit.sv */
`timescale 1ns / 1ps
module dmx_emit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dmx_pkg::emit_req_t          req,
  output logic                        out_valid,
  output logic [1:0]                  out_msg_kind,
  output logic [dmx_pkg::PEER_W-1:0]  out_dest_peer,
  output logic [dmx_pkg::MSG_W-1:0]   out_msg_value,
  output logic                        out_last
);
  import dmx_pkg::*;

  // One message is held back so the final one can carry last
  logic              pend_vld_r;
  msg_kind_t         pend_kind_r;
  logic [PEER_W-1:0] pend_dest_r;
  logic [MSG_W-1:0]  pend_value_r;

  logic              ov_r;
  logic [1:0]        okind_r;
  logic [PEER_W-1:0] odest_r;
  logic [MSG_W-1:0]  ovalue_r;
  logic              olast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      ov_r <= (req.push || req.flush) && pend_vld_r;
      if (req.push) begin
        pend_vld_r <= 1'b1;
      end else if (req.flush) begin
        pend_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.push) begin
      pend_kind_r  <= req.kind;
      pend_dest_r  <= req.dest;
      pend_value_r <= req.value;
    end
    okind_r  <= pend_kind_r;
    odest_r  <= pend_dest_r;
    ovalue_r <= pend_value_r;
    olast_r  <= req.flush;
  end

  assign out_valid     = ov_r;
  assign out_msg_kind  = okind_r;
  assign out_dest_peer = odest_r;
  assign out_msg_value = ovalue_r;
  assign out_last      = olast_r;

endmodule

/* src/dmx_ctrl.sv */
`timescale 1ns / 1ps
module dmx_ctrl #(
  parameter int MAX_SERVERS = dmx_pkg::DEF_MAX_SERVERS,
  parameter int STAMP_BITS  = dmx_pkg::DEF_STAMP_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [dmx_pkg::CMD_W-1:0]          in_cmd,
  input  logic [dmx_pkg::PEER_W-1:0]         in_peer,
  input  logic [dmx_pkg::MSG_W-1:0]          in_stamp,
  input  logic [dmx_pkg::PEER_W-1:0]         my_index,
  input  logic [$clog2(MAX_SERVERS+1)-1:0]   n_eff,
  input  logic                               live_ld,
  input  logic [$clog2(MAX_SERVERS+1)-1:0]   live_val,
  output logic                               wr_en,
  output logic [$clog2(MAX_SERVERS)-1:0]     wr_addr,
  output logic [dmx_pkg::ENT_W-1:0]          wr_data,
  output logic [$clog2(MAX_SERVERS)-1:0]     rd_addr,
  input  logic [dmx_pkg::ENT_W-1:0]          rd_data,
  output dmx_pkg::emit_req_t                 req
);
  import dmx_pkg::*;

  localparam int NW  = $clog2(MAX_SERVERS + 1);
  localparam int IW  = $clog2(MAX_SERVERS);
  localparam int KW  = (IW > PEER_W) ? IW : PEER_W;
  localparam int KW2 = (NW > PEER_W) ? NW : PEER_W;

  state_t                state_r, state_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [PEER_W-1:0]     peer_r, peer_nxt;
  logic [STAMP_BITS-1:0] stamp_r, stamp_nxt;
  logic [NW-1:0]         rd_idx_r, rd_idx_nxt;
  logic                  dv_r, dv_nxt;
  logic [IW-1:0]         didx_r, didx_nxt;
  logic                  pending_r, pending_nxt;
  logic                  finished_r, finished_nxt;
  logic [STAMP_BITS-1:0] highest_r, highest_nxt;
  logic [STAMP_BITS-1:0] own_r, own_nxt;
  logic [NW-1:0]         replies_r, replies_nxt;
  logic [NW-1:0]         live_r, live_nxt;
  logic [MAX_SERVERS-1:0] vld_r;
  logic                  rvld_r;

  logic [ENT_W-1:0]      ent;
  status_t               ent_st;
  logic                  ent_await;

  // Entries never written read as normal / not awaited
  assign ent       = rvld_r ? rd_data : '0;
  assign ent_st    = status_t'(ent[1:0]);
  assign ent_await = ent[2];
  assign busy      = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      pending_r  <= 1'b0;
      finished_r <= 1'b0;
      highest_r  <= '0;
      own_r      <= '0;
      replies_r  <= '0;
      live_r     <= NW'(1);
      dv_r       <= 1'b0;
      vld_r      <= '0;
      rvld_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pending_r  <= pending_nxt;
      finished_r <= finished_nxt;
      highest_r  <= highest_nxt;
      own_r      <= own_nxt;
      replies_r  <= replies_nxt;
      live_r     <= live_nxt;
      dv_r       <= dv_nxt;
      rvld_r     <= vld_r[rd_addr];
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    peer_r   <= peer_nxt;
    stamp_r  <= stamp_nxt;
    rd_idx_r <= rd_idx_nxt;
    didx_r   <= didx_nxt;
  end

  always_comb begin
    logic          is_self;
    logic          bad_peer;
    logic [NW-1:0] dec_rep;

    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    peer_nxt     = peer_r;
    stamp_nxt    = stamp_r;
    rd_idx_nxt   = rd_idx_r;
    dv_nxt       = 1'b0;
    didx_nxt     = didx_r;
    pending_nxt  = pending_r;
    finished_nxt = finished_r;
    highest_nxt  = highest_r;
    own_nxt      = own_r;
    replies_nxt  = replies_r;
    live_nxt     = live_ld ? live_val : live_r;
    wr_en        = 1'b0;
    wr_addr      = didx_r;
    wr_data      = ent;
    rd_addr      = IW'(in_peer);
    req          = '0;
    is_self      = (KW'(didx_r) == KW'(my_index));
    bad_peer     = (KW2'(in_peer) >= KW2'(n_eff)) || (in_peer == my_index);
    dec_rep      = (replies_r != '0) ? replies_r - NW'(1) : replies_r;

    case (state_r)
      // Take a request and set up its sweep or single access
      S_IDLE: begin
        if (start && !finished_r) begin
          cmd_nxt    = cmd_t'(in_cmd);
          peer_nxt   = in_peer;
          stamp_nxt  = STAMP_BITS'(in_stamp);
          rd_idx_nxt = '0;
          case (in_cmd)
            CMD_CREQ: begin
              if (!pending_r) begin
                pending_nxt = 1'b1;
                highest_nxt = highest_r + STAMP_BITS'(1);
                own_nxt     = highest_r + STAMP_BITS'(1);
                replies_nxt = '0;
                state_nxt   = (live_r > NW'(1)) ? S_SWEEP : S_TAIL;
              end
            end
            CMD_CREL: begin
              if (pending_r) begin
                pending_nxt = 1'b0;
                state_nxt   = S_SWEEP;
              end
            end
            CMD_DONE: begin
              finished_nxt = 1'b1;
              state_nxt    = S_SWEEP;
            end
            CMD_PREQ, CMD_PREP, CMD_PEXIT: begin
              if (!bad_peer) begin
                state_nxt = S_PEER;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Read entry k while deciding on entry k-1
      S_SWEEP: begin
        rd_addr = rd_idx_r[IW-1:0];
        if (rd_idx_r < n_eff) begin
          rd_idx_nxt = rd_idx_r + NW'(1);
          dv_nxt     = 1'b1;
          didx_nxt   = rd_idx_r[IW-1:0];
        end else begin
          state_nxt = (cmd_r == CMD_CREQ) ? S_TAIL : S_FLUSH;
        end
        if (dv_r) begin
          case (cmd_r)
            CMD_CREQ: begin
              if (!is_self && ent_st != ST_GONE) begin
                req.push    = 1'b1;
                req.kind    = MSG_REQ;
                req.dest    = PEER_W'(didx_r);
                req.value   = MSG_W'(own_r);
                wr_en       = 1'b1;
                wr_data     = {1'b1, ent[1:0]};
                replies_nxt = replies_r + NW'(1);
              end
            end
            CMD_CREL: begin
              if (ent_st == ST_WAITING) begin
                req.push  = 1'b1;
                req.kind  = MSG_REPLY;
                req.dest  = PEER_W'(didx_r);
                req.value = MSG_W'(my_index);
                wr_en     = 1'b1;
                wr_data   = {ent_await, ST_NORMAL};
              end
            end
            CMD_DONE: begin
              if (!is_self && ent_st != ST_GONE) begin
                req.push  = 1'b1;
                req.kind  = MSG_EXIT;
                req.dest  = PEER_W'(didx_r);
                req.value = MSG_W'(my_index);
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Single-entry update for peer messages
      S_PEER: begin
        wr_addr = IW'(peer_r);
        if (ent_st == ST_GONE) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_FLUSH;
          case (cmd_r)
            CMD_PREQ: begin
              if (stamp_r > highest_r) begin
                highest_nxt = stamp_r;
              end
              if (pending_r && ((own_r < stamp_r) ||
                                ((own_r == stamp_r) && (my_index < peer_r)))) begin
                wr_en   = 1'b1;
                wr_data = {ent_await, ST_WAITING};
              end else begin
                req.push  = 1'b1;
                req.kind  = MSG_REPLY;
                req.dest  = peer_r;
                req.value = MSG_W'(my_index);
              end
            end
            CMD_PREP, CMD_PEXIT: begin
              wr_en   = 1'b1;
              wr_data = {1'b0, (cmd_r == CMD_PEXIT) ? ST_GONE : ent_st};
              if (ent_await) begin
                replies_nxt = dec_rep;
                if (dec_rep == '0 && pending_r) begin
                  req.push  = 1'b1;
                  req.kind  = MSG_GRANT;
                  req.dest  = '0;
                  req.value = '0;
                end
              end
              if (cmd_r == CMD_PEXIT && live_r != '0) begin
                live_nxt = live_r - NW'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Grant when nobody had to be asked
      S_TAIL: begin
        state_nxt = S_FLUSH;
        if (replies_r == '0) begin
          req.push  = 1'b1;
          req.kind  = MSG_GRANT;
          req.dest  = '0;
          req.value = '0;
        end
      end

      S_FLUSH: begin
        req.flush = 1'b1;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
